### design/emmc_data_crc16_generator_top_defines.svh
// assertion macros shared by the emmc data crc16 generator rtl
// expects signals named clock and reset in the module that uses them
`ifndef EMMC_DATA_CRC16_GENERATOR_TOP_DEFINES_SVH
`define EMMC_DATA_CRC16_GENERATOR_TOP_DEFINES_SVH

// same-cycle implication, skipped while reset is high
`define EMMCCRC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, skipped while reset is high
`define EMMCCRC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/emmccrc_pkg.sv
// shared types, constants and crc helpers for the emmc data crc16 generator
// used by every module of the block; no dependencies
package emmccrc_pkg;

   localparam int BUS_W       = 8;
   localparam int LANES_DEF   = 8;
   localparam int CRC_W       = 16;
   localparam int LEN_W       = 12;
   localparam int IDX_W       = 4;
   localparam int CSR_IDX_W   = 1;
   localparam int RSP_DATA_W  = 48;

   localparam logic [CRC_W-1:0] CRC_POLY    = 16'h1021;
   localparam logic [LEN_W-1:0] COUNT_MAX   = 12'd4095;
   localparam logic [LEN_W-1:0] MIN_LEN_RST = 12'd4;
   localparam logic [LEN_W-1:0] MAX_LEN_RST = 12'd2048;
   localparam logic [IDX_W-1:0] TRAIL_LAST  = 4'd15;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_LEN = 1'b0,
      CSR_MAX_LEN = 1'b1
   } csr_index_type;

   // per-byte control seen by lanes, serial unit and trailer
   typedef struct packed {
      logic take;   // a byte transfer happens this cycle
      logic last;   // that byte closes the block
   } blk_ctl_type;

   // trailer status back to the input side
   typedef struct packed {
      logic busy;   // trailer bytes pending
      logic done;   // final trailer byte leaves this cycle
   } trail_sts_type;

   // one serial step of x^16 + x^12 + x^5 + 1
   function automatic logic [CRC_W-1:0] crc16_bit(input logic [CRC_W-1:0] crc,
                                                   input logic din);
      logic fb;
      fb = din ^ crc[CRC_W-1];
      return {crc[CRC_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
   endfunction

   // eight steps over a whole byte, msb first
   function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc,
                                                    input logic [BUS_W-1:0] data);
      logic [CRC_W-1:0] c;
      c = crc;
      for (int j = BUS_W - 1; j >= 0; j--) begin
         c = crc16_bit(c, data[j]);
      end
      return c;
   endfunction

endpackage

### design/emmccrc_lane.sv
// one data-line crc16 lane: one bit per byte transfer, cleared at block end
// depends on emmccrc_pkg
module emmccrc_lane (
   input  logic                              clock,
   input  logic                              reset,
   input  emmccrc_pkg::blk_ctl_type          ctl,
   input  logic                              bit_in,
   output logic [emmccrc_pkg::CRC_W-1:0]     crc_next
);

   logic [emmccrc_pkg::CRC_W-1:0] crc_ff;
   logic [emmccrc_pkg::CRC_W-1:0] crc_in;

   // crc including the current line bit
   assign crc_next = emmccrc_pkg::crc16_bit(crc_ff, bit_in);

   // advance on a transfer, restart after the final byte
   always_comb begin
      crc_in = crc_ff;
      if (ctl.take) begin
         crc_in = ctl.last ? '0 : crc_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= '0;
      end else begin
         crc_ff <= crc_in;
      end
   end

endmodule

### design/emmccrc_serial.sv
// whole-byte crc16 (msb first) and saturating byte counter of the block
// depends on emmccrc_pkg
module emmccrc_serial (
   input  logic                              clock,
   input  logic                              reset,
   input  emmccrc_pkg::blk_ctl_type          ctl,
   input  logic [emmccrc_pkg::BUS_W-1:0]     data_byte,
   output logic [emmccrc_pkg::CRC_W-1:0]     crc_next,
   output logic [emmccrc_pkg::LEN_W-1:0]     count_next
);

   logic [emmccrc_pkg::CRC_W-1:0] crc_ff;
   logic [emmccrc_pkg::CRC_W-1:0] crc_in;
   logic [emmccrc_pkg::LEN_W-1:0] count_ff;
   logic [emmccrc_pkg::LEN_W-1:0] count_in;

   // values including the current byte
   assign crc_next   = emmccrc_pkg::crc16_byte(crc_ff, data_byte);
   assign count_next = (count_ff < emmccrc_pkg::COUNT_MAX) ? count_ff + 1'b1 : count_ff;

   // advance on a transfer, restart after the final byte
   always_comb begin
      crc_in   = crc_ff;
      count_in = count_ff;
      if (ctl.take) begin
         crc_in   = ctl.last ? '0 : crc_next;
         count_in = ctl.last ? '0 : count_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff   <= '0;
         count_ff <= '0;
      end else begin
         crc_ff   <= crc_in;
         count_ff <= count_in;
      end
   end

endmodule

### design/emmccrc_trailer.sv
// merge stage: snapshots the lane crcs at block end and sends 16 bus-order bytes
// depends on emmccrc_pkg and the assertion macro header
`include "emmc_data_crc16_generator_top_defines.svh"

module emmccrc_trailer #(
   parameter int LANES = emmccrc_pkg::LANES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  emmccrc_pkg::blk_ctl_type          ctl,
   input  logic [emmccrc_pkg::CRC_W-1:0]     lane_crc [LANES],
   input  logic [emmccrc_pkg::CRC_W-1:0]     serial_crc,
   input  logic [emmccrc_pkg::LEN_W-1:0]     block_len,
   input  logic [emmccrc_pkg::LEN_W-1:0]     min_len,
   input  logic [emmccrc_pkg::LEN_W-1:0]     max_len,
   input  logic                              out_ready,
   output emmccrc_pkg::trail_sts_type        sts,
   output logic [emmccrc_pkg::BUS_W-1:0]     bus_byte,
   output logic [emmccrc_pkg::IDX_W-1:0]     byte_idx,
   output logic [emmccrc_pkg::CRC_W-1:0]     serial_out,
   output logic [emmccrc_pkg::LEN_W-1:0]     len_out,
   output logic                              len_bad,
   output logic                              trail_last
);

   logic [emmccrc_pkg::CRC_W-1:0] sh_ff [LANES];
   logic [emmccrc_pkg::CRC_W-1:0] sh_in [LANES];
   logic [emmccrc_pkg::CRC_W-1:0] serial_ff;
   logic [emmccrc_pkg::LEN_W-1:0] len_ff;
   logic                          bad_ff;
   logic [emmccrc_pkg::IDX_W-1:0] idx_ff;
   logic [emmccrc_pkg::IDX_W-1:0] idx_in;
   logic                          busy_ff;
   logic                          busy_in;
   logic                          cap;
   logic                          step;

   assign cap  = ctl.take & ctl.last;
   assign step = busy_ff & out_ready;

   assign sts.busy = busy_ff;
   assign sts.done = step & (idx_ff == emmccrc_pkg::TRAIL_LAST);

   // control: load on block end, count bytes out, free after the last one
   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (cap) begin
         busy_in = 1'b1;
         idx_in  = '0;
      end else if (step) begin
         idx_in = idx_ff + 1'b1;
         if (sts.done) begin
            busy_in = 1'b0;
         end
      end
   end

   // per-lane shift registers, msb goes out first
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         sh_in[i] = sh_ff[i];
         if (cap) begin
            sh_in[i] = lane_crc[i];
         end else if (step) begin
            sh_in[i] = {sh_ff[i][emmccrc_pkg::CRC_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   // snapshot payload
   always_ff @(posedge clock) begin
      for (int i = 0; i < LANES; i++) begin
         sh_ff[i] <= sh_in[i];
      end
      if (cap) begin
         serial_ff <= serial_crc;
         len_ff    <= block_len;
         bad_ff    <= (block_len < min_len) | (block_len > max_len);
      end
   end

   // bus byte from lane msbs, absent lines read as zero
   for (genvar g = 0; g < emmccrc_pkg::BUS_W; g++) begin : g_bus
      if (g < LANES) begin : g_used
         assign bus_byte[g] = sh_ff[g][emmccrc_pkg::CRC_W-1];
      end else begin : g_unused
         assign bus_byte[g] = 1'b0;
      end
   end

   assign byte_idx   = idx_ff;
   assign serial_out = serial_ff;
   assign len_out    = len_ff;
   assign len_bad    = bad_ff;
   assign trail_last = idx_ff == emmccrc_pkg::TRAIL_LAST;

   `EMMCCRC_ASSERT_NEXT(a_cap_starts, cap, busy_ff && idx_ff == '0, "trailer did not start")
   `EMMCCRC_ASSERT_NOW(a_no_overrun, cap, !busy_ff || sts.done, "block end while trailer busy")
   `EMMCCRC_ASSERT_NOW(a_idle_idx, !busy_ff, idx_ff == '0, "trailer index not parked at zero")
   `EMMCCRC_ASSERT_NEXT(a_stall_hold, busy_ff && !out_ready && !cap, $stable(idx_ff),
                        "trailer index moved during stall")

endmodule

### design/emmc_data_crc16_generator_top.sv
// emmc data crc16 generator, 8-bit bus: per-line crc lanes, serial crc, trailer
// depends on emmccrc_pkg, emmccrc_lane, emmccrc_serial, emmccrc_trailer
//
// usage:
//   req_* carries one block byte per transfer, req_tlast on the final byte.
//   rsp_* returns the 16-byte bus-order crc trailer of each block, rsp_tlast
//   on the sixteenth byte. csr_* writes min/max block length (index 0 / 1).
// throughput: one byte per cycle in and one trailer byte out, bar holds below.
// latency: trailer byte 0 is valid the cycle after the final byte transfer.
// bytes of the next block are taken while a trailer is still going out; only
// its final byte waits, until the last trailer byte of the previous block
// transfers (same cycle allowed). the trailer shift sets this.
// a stalled rsp_tready holds the trailer byte and index steady.
// reset: lanes, serial crc and counter clear, no trailer pending, limits
// return to 4 and 2048. block length saturates at 4095.
module emmc_data_crc16_generator_top #(
   parameter int LANES = emmccrc_pkg::LANES_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [7:0]                            req_tdata,   // [7:0] data_byte
   input  logic                                  req_tlast,   // block_end
   // response channel
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [7:0] crc_bus_byte, [11:8] crc_byte_index, [27:12] serial_checksum,
   // [39:28] block_length, [40] length_bad, [47:41] zero
   output logic [emmccrc_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                                  rsp_tlast,   // run_last
   // configuration
   input  logic                                  csr_we,
   input  logic [emmccrc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [emmccrc_pkg::LEN_W-1:0]         csr_wdata
);

   emmccrc_pkg::blk_ctl_type       ctl;
   emmccrc_pkg::trail_sts_type     sts;
   logic [emmccrc_pkg::CRC_W-1:0]  lane_next [LANES];
   logic [emmccrc_pkg::CRC_W-1:0]  serial_next;
   logic [emmccrc_pkg::LEN_W-1:0]  count_next;
   logic [emmccrc_pkg::LEN_W-1:0]  min_len_ff;
   logic [emmccrc_pkg::LEN_W-1:0]  min_len_in;
   logic [emmccrc_pkg::LEN_W-1:0]  max_len_ff;
   logic [emmccrc_pkg::LEN_W-1:0]  max_len_in;
   logic [emmccrc_pkg::BUS_W-1:0]  bus_byte;
   logic [emmccrc_pkg::IDX_W-1:0]  byte_idx;
   logic [emmccrc_pkg::CRC_W-1:0]  serial_out;
   logic [emmccrc_pkg::LEN_W-1:0]  len_out;
   logic                           len_bad;

   // a final byte waits until the previous trailer is clear
   assign req_tready = !sts.busy || !req_tlast || sts.done;
   assign ctl.take   = req_tvalid & req_tready;
   assign ctl.last   = req_tlast;

   // configuration writes
   always_comb begin
      min_len_in = min_len_ff;
      max_len_in = max_len_ff;
      if (csr_we) begin
         unique case (emmccrc_pkg::csr_index_type'(csr_index))
            emmccrc_pkg::CSR_MIN_LEN: min_len_in = csr_wdata;
            emmccrc_pkg::CSR_MAX_LEN: max_len_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_len_ff <= emmccrc_pkg::MIN_LEN_RST;
         max_len_ff <= emmccrc_pkg::MAX_LEN_RST;
      end else begin
         min_len_ff <= min_len_in;
         max_len_ff <= max_len_in;
      end
   end

   // one crc lane per data line, lane i sees bit 7-i
   for (genvar g = 0; g < LANES; g++) begin : g_lane
      emmccrc_lane u_lane (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .bit_in   (req_tdata[emmccrc_pkg::BUS_W-1-g]),
         .crc_next (lane_next[g])
      );
   end

   emmccrc_serial u_serial (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .data_byte  (req_tdata),
      .crc_next   (serial_next),
      .count_next (count_next)
   );

   emmccrc_trailer #(
      .LANES (LANES)
   ) u_trailer (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .lane_crc   (lane_next),
      .serial_crc (serial_next),
      .block_len  (count_next),
      .min_len    (min_len_ff),
      .max_len    (max_len_ff),
      .out_ready  (rsp_tready),
      .sts        (sts),
      .bus_byte   (bus_byte),
      .byte_idx   (byte_idx),
      .serial_out (serial_out),
      .len_out    (len_out),
      .len_bad    (len_bad),
      .trail_last (rsp_tlast)
   );

   // response packing
   assign rsp_tvalid = sts.busy;
   assign rsp_tdata  = {7'd0, len_bad, len_out, serial_out, byte_idx, bus_byte};

endmodule
